@@ hdl/vector3_math_unit_core_macros.svh @@
// ---------------------------------------------------------------------------
// vector3_math_unit_core assertion macros
// Implication checks on the core clock, disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef VECTOR3_MATH_UNIT_CORE_MACROS_SVH
`define VECTOR3_MATH_UNIT_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define V3MU_ASSERT_IMP(lbl, c, r, ante, cons) \
  lbl: assert property (@(posedge c) disable iff (r) (ante) |-> (cons)) \
    else $error("v3mu check failed");
// next-cycle implication
`define V3MU_ASSERT_NXT(lbl, c, r, ante, cons) \
  lbl: assert property (@(posedge c) disable iff (r) (ante) |=> (cons)) \
    else $error("v3mu check failed");
`else
`define V3MU_ASSERT_IMP(lbl, c, r, ante, cons)
`define V3MU_ASSERT_NXT(lbl, c, r, ante, cons)
`endif
`endif

@@ hdl/v3mu_pkg.sv @@
// ---------------------------------------------------------------------------
// v3mu_pkg
// Shared types and constants of the 3D vector math unit.
// ---------------------------------------------------------------------------
`default_nettype none

package v3mu_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int PORT_BITS     = 32;
  localparam int CFG_BITS      = 17;

  localparam logic [CFG_BITS-1:0] MIN_LENGTH_RST = 17'd1;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_DOT   = 3'd2,
    OP_CROSS = 3'd3,
    OP_NORM  = 3'd4,
    OP_UNIT  = 3'd5
  } op_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SAT   = 2'd1;
  localparam logic [1:0] ST_SHORT = 2'd2;

  typedef struct packed {
    logic [2:0]                  opcode;
    logic signed [PORT_BITS-1:0] a_x;
    logic signed [PORT_BITS-1:0] a_y;
    logic signed [PORT_BITS-1:0] a_z;
    logic signed [PORT_BITS-1:0] b_x;
    logic signed [PORT_BITS-1:0] b_y;
    logic signed [PORT_BITS-1:0] b_z;
  } cmd_t;

  typedef struct packed {
    logic signed [PORT_BITS-1:0] r_x;
    logic signed [PORT_BITS-1:0] r_y;
    logic signed [PORT_BITS-1:0] r_z;
    logic [1:0]                  status;
  } res_t;

  typedef struct packed {
    logic en;
    op_t  op;
  } stage_ctl_t;

endpackage

`default_nettype wire

@@ hdl/v3mu_lane.sv @@
// ---------------------------------------------------------------------------
// v3mu_lane
// One component lane: add/sub and two signed products, registered.
// ---------------------------------------------------------------------------
`default_nettype none

module v3mu_lane #(
  parameter int W = 32
) (
  input  wire                       clk,
  input  v3mu_pkg::stage_ctl_t      ctl,
  input  wire logic signed [W-1:0]  ai,
  input  wire logic signed [W-1:0]  aj,
  input  wire logic signed [W-1:0]  ak,
  input  wire logic signed [W-1:0]  bi,
  input  wire logic signed [W-1:0]  bj,
  input  wire logic signed [W-1:0]  bk,
  output logic signed [2*W-1:0]     p0,
  output logic signed [2*W-1:0]     p1,
  output logic signed [W:0]         s
);
  import v3mu_pkg::*;

  logic signed [W-1:0] m0a, m0b, m1a, m1b;
  logic signed [W:0]   sum;

  // operand routing per opcode; cross uses the two other components
  always_comb begin
    m0a = ai;
    m0b = ai;
    m1a = '0;
    m1b = '0;
    sum = '0;
    case (ctl.op) inside
      OP_ADD:   sum = (W+1)'(ai) + (W+1)'(bi);
      OP_SUB:   sum = (W+1)'(ai) - (W+1)'(bi);
      OP_DOT:   m0b = bi;
      OP_CROSS: begin
        m0a = aj;
        m0b = bk;
        m1a = ak;
        m1b = bj;
      end
      OP_NORM, OP_UNIT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      p0 <= m0a * m0b;
      p1 <= m1a * m1b;
      s  <= sum;
    end
  end

endmodule

`default_nettype wire

@@ hdl/v3mu_merge.sv @@
// ---------------------------------------------------------------------------
// v3mu_merge
// Combines lane results: floor shift, saturation, sum of squares.
// ---------------------------------------------------------------------------
`default_nettype none

module v3mu_merge #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  wire                        clk,
  input  v3mu_pkg::stage_ctl_t       ctl,
  input  wire logic signed [2*W-1:0] p0 [3],
  input  wire logic signed [2*W-1:0] p1 [3],
  input  wire logic signed [W:0]     s [3],
  output logic signed [W-1:0]        r [3],
  output logic [1:0]                 st,
  output logic [2*W-1:0]             sumsq
);
  import v3mu_pkg::*;

  localparam int SW = 2*W + 2;

  // {overflow, clamped value}
  function automatic logic [W:0] sat_w(input logic signed [SW-1:0] v);
    logic         ovf;
    logic [W-1:0] val;
    ovf = !((&v[SW-1:W-1]) || !(|v[SW-1:W-1]));
    if (!ovf) begin
      val = v[W-1:0];
    end else if (v[SW-1]) begin
      val = {1'b1, {(W-1){1'b0}}};
    end else begin
      val = {1'b0, {(W-1){1'b1}}};
    end
    return {ovf, val};
  endfunction

  logic signed [SW-1:0] dsum;
  logic signed [SW-1:0] cdif [3];
  logic [W:0]           sr [3];
  logic [W-1:0]         r_next [3];
  logic [1:0]           st_next;

  always_comb begin
    dsum = (SW'(p0[0]) + SW'(p0[1]) + SW'(p0[2])) >>> F;
    for (int i = 0; i < 3; i++) begin
      cdif[i] = (SW'(p0[i]) - SW'(p1[i])) >>> F;
      sr[i]   = '0;
    end
    case (ctl.op) inside
      OP_ADD, OP_SUB: begin
        for (int i = 0; i < 3; i++) sr[i] = sat_w(SW'(s[i]));
      end
      OP_DOT:   sr[0] = sat_w(dsum);
      OP_CROSS: begin
        for (int i = 0; i < 3; i++) sr[i] = sat_w(cdif[i]);
      end
      default: ;
    endcase
    for (int i = 0; i < 3; i++) r_next[i] = sr[i][W-1:0];
    st_next = (sr[0][W] || sr[1][W] || sr[2][W]) ? ST_SAT : ST_OK;
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      for (int i = 0; i < 3; i++) r[i] <= signed'(r_next[i]);
      st    <= st_next;
      // squares are non-negative and their sum fits 2W bits
      sumsq <= (2*W)'(p0[0]) + (2*W)'(p0[1]) + (2*W)'(p0[2]);
    end
  end

endmodule

`default_nettype wire

@@ hdl/v3mu_sqrt.sv @@
// ---------------------------------------------------------------------------
// v3mu_sqrt
// Pipelined floor square root, one root bit per stage.
// ---------------------------------------------------------------------------
`default_nettype none

module v3mu_sqrt #(
  parameter int W = 32
) (
  input  wire               clk,
  input  wire               en,
  input  wire [2*W-1:0]     x,
  output logic [W-1:0]      root
);

  localparam int RW = W + 3;

  logic [RW-1:0]  rem_q  [W-1];
  logic [2*W-1:0] x_q    [W-1];
  logic [W-1:0]   root_q [W];

  for (genvar k = 0; k < W; k++) begin : g_st
    logic [RW-1:0]  rin, r2, t, rn;
    logic [W-1:0]   qin, qn;
    logic [2*W-1:0] xin;

    if (k == 0) begin : g_first
      assign rin = '0;
      assign qin = '0;
      assign xin = x;
    end else begin : g_rest
      assign rin = rem_q[k-1];
      assign qin = root_q[k-1];
      assign xin = x_q[k-1];
    end

    assign r2 = {rin[RW-3:0], xin[2*W-1:2*W-2]};
    assign t  = RW'({qin, 2'b01});
    assign rn = (r2 >= t) ? (r2 - t) : r2;
    assign qn = {qin[W-2:0], (r2 >= t)};

    always_ff @(posedge clk) begin
      if (en) root_q[k] <= qn;
    end

    if (k < W-1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[k] <= rn;
          x_q[k]   <= {xin[2*W-3:0], 2'b00};
        end
      end
    end
  end

  assign root = root_q[W-1];

endmodule

`default_nettype wire

@@ hdl/v3mu_div.sv @@
// ---------------------------------------------------------------------------
// v3mu_div
// Pipelined restoring divider: (mag << F) / dvs, one quotient bit per stage.
// ---------------------------------------------------------------------------
`default_nettype none

module v3mu_div #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  wire                clk,
  input  wire                en,
  input  wire [W-1:0]        mag,
  input  wire [W-1:0]        dvs,
  output logic [W+F-1:0]     quo
);

  localparam int QW = W + F;

  logic [QW-1:0] dq_q  [QW];
  logic [W-1:0]  rem_q [QW-1];
  logic [W-1:0]  d_q   [QW-1];

  for (genvar k = 0; k < QW; k++) begin : g_st
    logic [W-1:0]  rin, din;
    logic [QW-1:0] dqin;
    logic [W:0]    r2, rn;
    logic          ge;

    if (k == 0) begin : g_first
      assign rin  = '0;
      assign din  = dvs;
      assign dqin = {mag, {F{1'b0}}};
    end else begin : g_rest
      assign rin  = rem_q[k-1];
      assign din  = d_q[k-1];
      assign dqin = dq_q[k-1];
    end

    // dividend bits shift out at the top, quotient bits shift in at the bottom
    assign r2 = {rin, dqin[QW-1]};
    assign ge = (r2 >= {1'b0, din});
    assign rn = ge ? (r2 - {1'b0, din}) : r2;

    always_ff @(posedge clk) begin
      if (en) dq_q[k] <= {dqin[QW-2:0], ge};
    end

    if (k < QW-1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[k] <= rn[W-1:0];
          d_q[k]   <= din;
        end
      end
    end
  end

  assign quo = dq_q[QW-1];

endmodule

`default_nettype wire

@@ hdl/vector3_math_unit_core.sv @@
// Timing from cmd transfer to res_valid is the same for every opcode.
// Throughput: one item per cycle unless the output stalls; set by the fully pipelined
//   square root (WORD_BITS stages) and the three divider lanes (WORD_BITS+FRAC_BITS stages).
// Reset: rst (sync, active high) empties the pipeline and sets min_length to 1.
// ---------------------------------------------------------------------------
// vector3_math_unit_core
// 3D vector arithmetic on signed fixed-point vectors: add, sub, dot, cross,
// norm and unit vector, with saturation and short-vector status.
// ---------------------------------------------------------------------------
`default_nettype none
`include "vector3_math_unit_core_macros.svh"

module vector3_math_unit_core #(
  parameter int WORD_BITS = v3mu_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = v3mu_pkg::FRAC_BITS_DEF
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               cmd_valid,
  output logic                              cmd_ready,
  input  v3mu_pkg::cmd_t                    cmd,
  output logic                              res_valid,
  input  wire                               res_ready,
  output v3mu_pkg::res_t                    res,
  input  wire                               cfg_we,
  input  wire [v3mu_pkg::CFG_BITS-1:0]      cfg_wdata
);
  import v3mu_pkg::*;

  localparam int W   = WORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int QW  = W + F;
  // lane, merge, sqrt stages, norm check, divider stages
  localparam int L   = W + QW + 3;
  localparam int NCW = (W > CFG_BITS) ? W : CFG_BITS;

  // item context that rides alongside the arithmetic
  typedef struct packed {
    op_t              op;
    logic [2:0][W-1:0] a;
    logic [2:0][W-1:0] r;
    logic [1:0]       st;
  } side_t;

  typedef struct packed {
    side_t        sd;
    logic [W-1:0] norm;
    logic         short_len;
  } nside_t;

  logic [CFG_BITS-1:0] min_length;
  logic [L-1:0]        vld;
  logic                adv;

  // --- configuration -------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      min_length <= MIN_LENGTH_RST;
    end else if (cfg_we) begin
      min_length <= cfg_wdata;
    end
  end

  // --- flow control --------------------------------------------------------
  // The whole pipe moves unless a finished item sits in the last stage while
  // the output register holds an untaken result. Bubbles keep moving, so a
  // new transfer is taken even while res waits.
  assign adv       = !(res_valid && !res_ready && vld[L-1]);
  assign cmd_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[L-2:0], cmd_valid};
    end
  end

  // --- lanes: add/sub and products ----------------------------------------
  op_t                 cmd_op;
  logic signed [W-1:0] ca [3];
  logic signed [W-1:0] cb [3];
  stage_ctl_t          lane_ctl;
  logic signed [2*W-1:0] p0 [3];
  logic signed [2*W-1:0] p1 [3];
  logic signed [W:0]     sv [3];

  assign cmd_op   = op_t'(cmd.opcode);
  assign ca[0]    = cmd.a_x[W-1:0];
  assign ca[1]    = cmd.a_y[W-1:0];
  assign ca[2]    = cmd.a_z[W-1:0];
  assign cb[0]    = cmd.b_x[W-1:0];
  assign cb[1]    = cmd.b_y[W-1:0];
  assign cb[2]    = cmd.b_z[W-1:0];
  assign lane_ctl = '{en: adv, op: cmd_op};

  for (genvar i = 0; i < 3; i++) begin : g_lane
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;
    v3mu_lane #(.W(W)) u_lane (
      .clk (clk),
      .ctl (lane_ctl),
      .ai  (ca[i]),
      .aj  (ca[J]),
      .ak  (ca[K]),
      .bi  (cb[i]),
      .bj  (cb[J]),
      .bk  (cb[K]),
      .p0  (p0[i]),
      .p1  (p1[i]),
      .s   (sv[i])
    );
  end

  side_t side1;
  always_ff @(posedge clk) begin
    if (adv) begin
      side1.op <= cmd_op;
      for (int i = 0; i < 3; i++) side1.a[i] <= ca[i];
      side1.r  <= '0;
      side1.st <= ST_OK;
    end
  end

  // --- merge: dot/cross/add/sub results and sum of squares ---------------
  stage_ctl_t          mrg_ctl;
  logic signed [W-1:0] mr [3];
  logic [1:0]          mst;
  logic [2*W-1:0]      sumsq;

  assign mrg_ctl = '{en: adv, op: side1.op};

  v3mu_merge #(.W(W), .F(F)) u_merge (
    .clk   (clk),
    .ctl   (mrg_ctl),
    .p0    (p0),
    .p1    (p1),
    .s     (sv),
    .r     (mr),
    .st    (mst),
    .sumsq (sumsq)
  );

  side_t side2;
  side_t side2_full;
  always_ff @(posedge clk) begin
    if (adv) side2 <= side1;
  end

  always_comb begin
    side2_full = side2;
    for (int i = 0; i < 3; i++) side2_full.r[i] = mr[i];
    side2_full.st = mst;
  end

  // --- square root, context delayed to match ------------------------------
  logic [W-1:0] root;
  side_t        sd [W];

  v3mu_sqrt #(.W(W)) u_sqrt (
    .clk  (clk),
    .en   (adv),
    .x    (sumsq),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      sd[0] <= side2_full;
      for (int k = 1; k < W; k++) sd[k] <= sd[k-1];
    end
  end

  // --- norm check: norm result, short-vector flag -------------------------
  nside_t ns, ns_next;

  always_comb begin
    ns_next.sd        = sd[W-1];
    ns_next.norm      = root;
    ns_next.short_len = (root == '0) || (NCW'(root) < NCW'(min_length));
    if (sd[W-1].op == OP_NORM) begin
      if (root[W-1]) begin
        ns_next.sd.r[0] = {1'b0, {(W-1){1'b1}}};
        ns_next.sd.st   = ST_SAT;
      end else begin
        ns_next.sd.r[0] = root;
        ns_next.sd.st   = ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) ns <= ns_next;
  end

  // --- divider lanes for the unit vector ----------------------------------
  logic [W-1:0]  mag [3];
  logic [QW-1:0] quo [3];
  nside_t        dd [QW];

  for (genvar i = 0; i < 3; i++) begin : g_div
    // magnitude of a component; the most negative value maps to 2^(W-1)
    assign mag[i] = ns.sd.a[i][W-1] ? W'(-signed'(ns.sd.a[i])) : ns.sd.a[i];

    v3mu_div #(.W(W), .F(F)) u_div (
      .clk (clk),
      .en  (adv),
      .mag (mag[i]),
      .dvs (ns.norm),
      .quo (quo[i])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dd[0] <= ns;
      for (int k = 1; k < QW; k++) dd[k] <= dd[k-1];
    end
  end

  // --- final: sign, saturation, status ------------------------------------
  side_t fin;

  always_comb begin
    logic         ovf_any;
    logic         neg;
    logic         ovf;
    logic [QW-1:0] q;
    fin     = dd[QW-1].sd;
    ovf_any = 1'b0;
    neg     = 1'b0;
    ovf     = 1'b0;
    q       = '0;
    if (fin.op == OP_UNIT) begin
      if (dd[QW-1].short_len) begin
        fin.r  = '0;
        fin.st = ST_SHORT;
      end else begin
        for (int i = 0; i < 3; i++) begin
          q   = quo[i];
          neg = dd[QW-1].sd.a[i][W-1];
          if (neg) begin
            // -2^(W-1) is still in range
            ovf = (|q[QW-1:W]) || (q[W-1] && (|q[W-2:0]));
            fin.r[i] = ovf ? {1'b1, {(W-1){1'b0}}} : W'(-q[W-1:0]);
          end else begin
            ovf = |q[QW-1:W-1];
            fin.r[i] = ovf ? {1'b0, {(W-1){1'b1}}} : q[W-1:0];
          end
          ovf_any = ovf_any || ovf;
        end
        fin.st = ovf_any ? ST_SAT : ST_OK;
      end
    end
  end

  // --- output register -----------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      if (adv && vld[L-1])        res_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && vld[L-1]) begin
      res.r_x    <= PORT_BITS'(signed'(fin.r[0]));
      res.r_y    <= PORT_BITS'(signed'(fin.r[1]));
      res.r_z    <= PORT_BITS'(signed'(fin.r[2]));
      res.status <= fin.st;
    end
  end

  // --- checks --------------------------------------------------------------
  logic res_zero;
  assign res_zero = (res.r_x == '0) && (res.r_y == '0) && (res.r_z == '0);

  `V3MU_ASSERT_IMP(a_stall_blocks, clk, rst, res_valid && !res_ready && vld[L-1], !cmd_ready)
  `V3MU_ASSERT_IMP(a_short_zero, clk, rst, res_valid && res.status == ST_SHORT, res_zero)
  `V3MU_ASSERT_NXT(a_fill, clk, rst, cmd_valid && cmd_ready, vld[0])
  `V3MU_ASSERT_NXT(a_drain, clk, rst, vld[L-1] && cmd_ready, res_valid)

endmodule

`default_nettype wire
